// File: hw/rtl/mlc_pkg.sv
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared types, constants and control program for the moisture loop
// controller: register map, reset values, arithmetic limits and the
// microcode table that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mlc_pkg;

  // default number of channels that keep loop state
  localparam int NUM_CHANNELS_DEFAULT = 2;

  // configuration register map
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_ERROR_NOW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_ERROR_PREV    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DRIVE_PREV    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_OFFSET_CH0     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_OFFSET_CH1     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_RECIP_GAIN_CH0 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_RECIP_GAIN_CH1 = 3'd6;

  // register reset values
  localparam logic signed [15:0] RST_GAIN_ERROR_NOW     = 16'sd256;
  localparam logic signed [15:0] RST_GAIN_ERROR_PREV    = 16'sd256;
  localparam logic signed [15:0] RST_GAIN_DRIVE_PREV    = 16'sd256;
  localparam logic [15:0]        RST_CAL_OFFSET_CH0     = 16'd26683;
  localparam logic [15:0]        RST_CAL_OFFSET_CH1     = 16'd28355;
  localparam logic signed [15:0] RST_CAL_RECIP_GAIN_CH0 = -16'sd10146;
  localparam logic signed [15:0] RST_CAL_RECIP_GAIN_CH1 = -16'sd8717;

  // moisture scaling and limits
  localparam int MOIST_SHIFT = 20;
  localparam logic signed [39:0] MOIST_BIAS = 40'sd1048575;
  localparam logic signed [39:0] MOIST_HI   = 40'sd1023;
  localparam logic signed [39:0] MOIST_LO   = -40'sd1024;

  // drive scaling and limits
  localparam int DRIVE_SHIFT = 8;
  localparam logic signed [41:0] DRIVE_BIAS = 42'sd255;
  localparam logic signed [41:0] DRIVE_HI   = 42'sd8388607;
  localparam logic signed [41:0] DRIVE_LO   = -42'sd8388608;

  // drive to duty mapping, divide by ten as multiply by 205 then shift by 11
  localparam logic signed [23:0] DRIVE_FULL = 24'sd1000;
  localparam logic [6:0]         DUTY_FULL  = 7'd100;
  localparam logic [7:0]         RECIP_TEN  = 8'd205;
  localparam int                 TEN_SHIFT  = 11;

  // pwm output number base
  localparam logic [1:0] PWM_BASE = 2'd2;

  // program step counter
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CAL   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MOIST = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ERR   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ACC0  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_ACC1  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DRIVE = 3'd6;
  localparam logic [STEP_W-1:0] STEP_OUT   = 3'd7;

  // advance conditions
  localparam logic [1:0] COND_GO       = 2'd0;
  localparam logic [1:0] COND_IN_TAKEN = 2'd1;
  localparam logic [1:0] COND_OUT_FREE = 2'd2;

  // multiplier operand pairs
  localparam logic [1:0] MUL_CAL   = 2'd0;
  localparam logic [1:0] MUL_EPREV = 2'd1;
  localparam logic [1:0] MUL_UPREV = 2'd2;
  localparam logic [1:0] MUL_ENOW  = 2'd3;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // one control word of the program
  typedef struct packed {
    logic [1:0]        cond;
    logic [STEP_W-1:0] next;
    logic              capture;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic [1:0]        acc_op;
    logic              m_en;
    logic              e_en;
    logic              u_en;
    logic              out_load;
  } uword_t;

  // control program
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    w.cond    = COND_GO;
    w.mul_sel = MUL_CAL;
    w.acc_op  = ACC_HOLD;
    case (step)
      STEP_IDLE: begin
        w.cond    = COND_IN_TAKEN;
        w.next    = STEP_CAL;
        w.capture = 1'b1;
      end
      STEP_CAL: begin
        w.next    = STEP_MOIST;
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_CAL;
      end
      STEP_MOIST: begin
        w.next    = STEP_ERR;
        w.m_en    = 1'b1;
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_EPREV;
      end
      STEP_ERR: begin
        w.next    = STEP_ACC0;
        w.e_en    = 1'b1;
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_UPREV;
        w.acc_op  = ACC_LOAD;
      end
      STEP_ACC0: begin
        w.next    = STEP_ACC1;
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_ENOW;
        w.acc_op  = ACC_ADD;
      end
      STEP_ACC1: begin
        w.next   = STEP_DRIVE;
        w.acc_op = ACC_ADD;
      end
      STEP_DRIVE: begin
        w.next = STEP_OUT;
        w.u_en = 1'b1;
      end
      STEP_OUT: begin
        w.cond     = COND_OUT_FREE;
        w.next     = STEP_IDLE;
        w.out_load = 1'b1;
      end
      default: begin
        w.next = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/moisture_loop_controller.sv
// ----------------------------------------------------------------------------
// moisture_loop_controller
// Two-channel soil-moisture regulator: calibrates an ADC reading to moisture,
// runs a first-order control law per channel and maps the drive to a duty.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | channel, adc bytes, transfer_ok, setpoint,
//          |                      | rain_present, device_address
//  out     | out_valid / out_ready| out_channel, pwm_select, duty_percent,
//          |                      | moisture, out_address, valve controls
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Each item is processed by a microcode program of eight steps that drives
//  one shared 16x24 multiplier, four products per item; a new item is not
//  taken until the previous one has passed the last step.
//  in_ready is high only at the program's idle step; the next item is taken
//  while the previous result still waits in the output register.
//  The last step waits while the output register holds an untaken result.
//  Reset restores register defaults, clears per-channel loop state and
//  returns the program to the idle step. cfg_ready is always high.
//
`default_nettype none

module moisture_loop_controller #(
  parameter int NUM_CHANNELS = mlc_pkg::NUM_CHANNELS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input item
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            channel,
  input  wire logic [7:0]                      adc_byte_hi,
  input  wire logic [7:0]                      adc_byte_lo,
  input  wire logic                            transfer_ok,
  input  wire logic [6:0]                      setpoint,
  input  wire logic                            rain_present,
  input  wire logic [6:0]                      device_address,
  // result item
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_channel,
  output logic [1:0]                           pwm_select,
  output logic [6:0]                           duty_percent,
  output logic signed [10:0]                   moisture,
  output logic [6:0]                           out_address,
  output logic                                 rain_valve_open,
  output logic                                 mains_valve_open,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // configuration registers
  logic signed [15:0] gain_error_now;
  logic signed [15:0] gain_error_prev;
  logic signed [15:0] gain_drive_prev;
  logic [15:0]        cal_offset_ch0;
  logic [15:0]        cal_offset_ch1;
  logic signed [15:0] cal_recip_gain_ch0;
  logic signed [15:0] cal_recip_gain_ch1;

  // sequencer
  logic [mlc_pkg::STEP_W-1:0] step;
  logic [mlc_pkg::STEP_W-1:0] step_next;
  mlc_pkg::uword_t            uw;
  logic                       advance;
  logic                       out_free;

  // captured item
  logic               ch_q;
  logic signed [17:0] diff;
  logic [6:0]         setpoint_q;
  logic               rain_q;
  logic [6:0]         addr_q;

  // datapath
  logic signed [15:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [39:0] product;
  logic signed [39:0] p;
  logic signed [41:0] acc;
  logic signed [10:0] m;
  logic signed [11:0] e;
  logic signed [23:0] u;

  // per-channel loop state
  logic signed [15:0] previous_error [NUM_CHANNELS];
  logic signed [23:0] previous_drive [NUM_CHANNELS];
  logic [IDX_W-1:0]   slot;
  logic               has_slot;
  logic signed [15:0] e_prev;
  logic signed [23:0] u_prev;

  // combinational helpers
  logic [11:0]        reading;
  logic [15:0]        offset_sel;
  logic signed [17:0] diff_next;
  logic signed [39:0] m_quot;
  logic signed [10:0] m_next;
  logic signed [11:0] sp_ext;
  logic signed [41:0] p_ext;
  logic signed [41:0] u_quot;
  logic signed [23:0] u_next;
  logic [17:0]        tenth_prod;
  logic [6:0]         duty_next;

  // program control
  assign uw        = mlc_pkg::ucode_rom(step);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (uw.cond == mlc_pkg::COND_IN_TAKEN);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (uw.cond)
      mlc_pkg::COND_GO:       advance = 1'b1;
      mlc_pkg::COND_IN_TAKEN: advance = in_valid;
      mlc_pkg::COND_OUT_FREE: advance = out_free;
      default:                advance = 1'b0;
    endcase
    step_next = advance ? uw.next : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mlc_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // configuration register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_error_now     <= mlc_pkg::RST_GAIN_ERROR_NOW;
      gain_error_prev    <= mlc_pkg::RST_GAIN_ERROR_PREV;
      gain_drive_prev    <= mlc_pkg::RST_GAIN_DRIVE_PREV;
      cal_offset_ch0     <= mlc_pkg::RST_CAL_OFFSET_CH0;
      cal_offset_ch1     <= mlc_pkg::RST_CAL_OFFSET_CH1;
      cal_recip_gain_ch0 <= mlc_pkg::RST_CAL_RECIP_GAIN_CH0;
      cal_recip_gain_ch1 <= mlc_pkg::RST_CAL_RECIP_GAIN_CH1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlc_pkg::REG_GAIN_ERROR_NOW:     gain_error_now     <= cfg_data;
        mlc_pkg::REG_GAIN_ERROR_PREV:    gain_error_prev    <= cfg_data;
        mlc_pkg::REG_GAIN_DRIVE_PREV:    gain_drive_prev    <= cfg_data;
        mlc_pkg::REG_CAL_OFFSET_CH0:     cal_offset_ch0     <= cfg_data;
        mlc_pkg::REG_CAL_OFFSET_CH1:     cal_offset_ch1     <= cfg_data;
        mlc_pkg::REG_CAL_RECIP_GAIN_CH0: cal_recip_gain_ch0 <= cfg_data;
        mlc_pkg::REG_CAL_RECIP_GAIN_CH1: cal_recip_gain_ch1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // reading minus offset, formed as the item is taken
  always_comb begin
    reading    = transfer_ok ? {adc_byte_hi[3:0], adc_byte_lo} : 12'd0;
    offset_sel = channel ? cal_offset_ch1 : cal_offset_ch0;
    diff_next  = $signed({2'b00, reading, 4'b0000}) - $signed({2'b00, offset_sel});
  end

  always_ff @(posedge clk) begin
    if (uw.capture && advance) begin
      ch_q       <= channel;
      diff       <= diff_next;
      setpoint_q <= setpoint;
      rain_q     <= rain_present;
      addr_q     <= device_address;
    end
  end

  // loop state lookup for the captured channel
  assign slot     = IDX_W'(ch_q);
  assign has_slot = ({31'd0, ch_q} < NUM_CHANNELS);
  assign e_prev   = has_slot ? previous_error[slot] : 16'sd0;
  assign u_prev   = has_slot ? previous_drive[slot] : 24'sd0;

  // shared multiplier operand select
  always_comb begin
    case (uw.mul_sel)
      mlc_pkg::MUL_CAL: begin
        mul_a = ch_q ? cal_recip_gain_ch1 : cal_recip_gain_ch0;
        mul_b = {{6{diff[17]}}, diff};
      end
      mlc_pkg::MUL_EPREV: begin
        mul_a = gain_error_prev;
        mul_b = {{8{e_prev[15]}}, e_prev};
      end
      mlc_pkg::MUL_UPREV: begin
        mul_a = gain_drive_prev;
        mul_b = u_prev;
      end
      mlc_pkg::MUL_ENOW: begin
        mul_a = gain_error_now;
        mul_b = {{12{e[11]}}, e};
      end
      default: begin
        mul_a = 16'sd0;
        mul_b = 24'sd0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // product register and accumulator
  assign p_ext = {{2{p[39]}}, p};

  always_ff @(posedge clk) begin
    if (uw.mul_en) begin
      p <= product;
    end
    case (uw.acc_op)
      mlc_pkg::ACC_LOAD: acc <= p_ext;
      mlc_pkg::ACC_ADD:  acc <= acc + p_ext;
      default: ;
    endcase
  end

  // moisture: divide by 2^20 toward zero, then clamp
  always_comb begin
    m_quot = (p + (p[39] ? mlc_pkg::MOIST_BIAS : 40'sd0)) >>> mlc_pkg::MOIST_SHIFT;
    if (m_quot > mlc_pkg::MOIST_HI) begin
      m_next = mlc_pkg::MOIST_HI[10:0];
    end else if (m_quot < mlc_pkg::MOIST_LO) begin
      m_next = mlc_pkg::MOIST_LO[10:0];
    end else begin
      m_next = m_quot[10:0];
    end
  end

  // drive: divide by 2^8 toward zero, then clamp to 24 bits
  always_comb begin
    u_quot = (acc + (acc[41] ? mlc_pkg::DRIVE_BIAS : 42'sd0)) >>> mlc_pkg::DRIVE_SHIFT;
    if (u_quot > mlc_pkg::DRIVE_HI) begin
      u_next = mlc_pkg::DRIVE_HI[23:0];
    end else if (u_quot < mlc_pkg::DRIVE_LO) begin
      u_next = mlc_pkg::DRIVE_LO[23:0];
    end else begin
      u_next = u_quot[23:0];
    end
  end

  assign sp_ext = {5'b00000, setpoint_q};

  always_ff @(posedge clk) begin
    if (uw.m_en) begin
      m <= m_next;
    end
    if (uw.e_en) begin
      e <= sp_ext - {m[10], m};
    end
    if (uw.u_en) begin
      u <= u_next;
    end
  end

  // duty from drive, tenths by reciprocal multiply
  always_comb begin
    tenth_prod = u[9:0] * mlc_pkg::RECIP_TEN;
    if (u >= mlc_pkg::DRIVE_FULL) begin
      duty_next = mlc_pkg::DUTY_FULL;
    end else if (u <= 24'sd0) begin
      duty_next = 7'd0;
    end else begin
      duty_next = tenth_prod[17:mlc_pkg::TEN_SHIFT];
    end
  end

  // loop state update when the result is handed to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        previous_error[i] <= 16'sd0;
        previous_drive[i] <= 24'sd0;
      end
    end else if (uw.out_load && advance && has_slot) begin
      previous_error[slot] <= {{4{e[11]}}, e};
      previous_drive[slot] <= u;
    end
  end

  // output register, freed by an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.out_load && advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.out_load && advance) begin
      out_channel      <= ch_q;
      pwm_select       <= mlc_pkg::PWM_BASE + {1'b0, ch_q};
      duty_percent     <= duty_next;
      moisture         <= m;
      out_address      <= addr_q;
      rain_valve_open  <= rain_q;
      mains_valve_open <= !rain_q;
    end
  end

  // a taken item always starts the calibration step
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (step == mlc_pkg::STEP_CAL))
    else $error("item transfer not followed by calibration step");

  // a new result only appears after the output step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(step) == mlc_pkg::STEP_OUT))
    else $error("result loaded outside the output step");

  // duty stays within full scale
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_percent <= mlc_pkg::DUTY_FULL))
    else $error("duty above full scale");

  // a held result is never overwritten before it is taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(duty_percent) && $stable(moisture)))
    else $error("held result changed");

endmodule

`default_nettype wire

// File: dv/moisture_loop_controller_test.sv
// ----------------------------------------------------------------------------
// moisture_loop_controller_test
// Self-checking bench for the moisture loop controller. Sensor items are sent
// over the input handshake while results are taken with random back-pressure.
// A local loop predictor keeps its own register copy and per-channel error and
// drive history. Every result is checked field by field against the oldest
// prediction. Directed limit cases run first, then random phases under many
// register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module moisture_loop_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int QUIET_CYCLES  = 16;
  localparam int PHASE_ITEMS   = 100;
  localparam int NUM_PHASES    = 8;
  localparam int NUM_REGS      = 7;
  localparam logic [mlc_pkg::CFG_INDEX_W-1:0] REG_INDEX_UNUSED = 3'd7;

  // register setting styles for the random phases
  typedef enum int {
    SET_DEFAULT,
    SET_GENTLE,
    SET_GENTLE_CAL,
    SET_FULL_RANDOM,
    SET_EXTREMES
  } setting_kind_t;

  typedef struct packed {
    logic       ch;
    logic [7:0] hi;
    logic [7:0] lo;
    logic       ok;
    logic [6:0] sp;
    logic       rain;
    logic [6:0] addr;
  } sensor_item_t;

  typedef struct packed {
    logic               ch;
    logic [1:0]         pwm;
    logic [6:0]         duty;
    logic signed [10:0] moist;
    logic [6:0]         addr;
    logic               rain_valve;
    logic               mains_valve;
  } valve_cmd_t;

  // clock, reset and block inputs
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            channel = 1'b0;
  logic [7:0]                      adc_byte_hi = '0;
  logic [7:0]                      adc_byte_lo = '0;
  logic                            transfer_ok = 1'b0;
  logic [6:0]                      setpoint = '0;
  logic                            rain_present = 1'b0;
  logic [6:0]                      device_address = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [mlc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]                     cfg_data = '0;

  // block outputs
  logic               in_ready;
  logic               out_valid;
  logic               out_channel;
  logic [1:0]         pwm_select;
  logic [6:0]         duty_percent;
  logic signed [10:0] moisture;
  logic [6:0]         out_address;
  logic               rain_valve_open;
  logic               mains_valve_open;
  logic               cfg_ready;

  // predictor state
  logic [15:0]        cfg_shadow [NUM_REGS];
  logic signed [15:0] err_hist   [2];
  logic signed [23:0] drive_hist [2];
  valve_cmd_t         pending_cmds [$];

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  cfg_writes    = 0;
  int  settings_used = 1;
  int  cycle_count   = 0;
  bit  steady_flow   = 1'b0;
  int  stall_left    = 0;

  moisture_loop_controller i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .channel          (channel),
    .adc_byte_hi      (adc_byte_hi),
    .adc_byte_lo      (adc_byte_lo),
    .transfer_ok      (transfer_ok),
    .setpoint         (setpoint),
    .rain_present     (rain_present),
    .device_address   (device_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .pwm_select       (pwm_select),
    .duty_percent     (duty_percent),
    .moisture         (moisture),
    .out_address      (out_address),
    .rain_valve_open  (rain_valve_open),
    .mains_valve_open (mains_valve_open),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("moisture_loop_controller_test NOT OK");
      $finish;
    end
  end

  // predictor back to reset state
  function automatic void reset_loop_model();
    cfg_shadow[mlc_pkg::REG_GAIN_ERROR_NOW]     = mlc_pkg::RST_GAIN_ERROR_NOW;
    cfg_shadow[mlc_pkg::REG_GAIN_ERROR_PREV]    = mlc_pkg::RST_GAIN_ERROR_PREV;
    cfg_shadow[mlc_pkg::REG_GAIN_DRIVE_PREV]    = mlc_pkg::RST_GAIN_DRIVE_PREV;
    cfg_shadow[mlc_pkg::REG_CAL_OFFSET_CH0]     = mlc_pkg::RST_CAL_OFFSET_CH0;
    cfg_shadow[mlc_pkg::REG_CAL_OFFSET_CH1]     = mlc_pkg::RST_CAL_OFFSET_CH1;
    cfg_shadow[mlc_pkg::REG_CAL_RECIP_GAIN_CH0] = mlc_pkg::RST_CAL_RECIP_GAIN_CH0;
    cfg_shadow[mlc_pkg::REG_CAL_RECIP_GAIN_CH1] = mlc_pkg::RST_CAL_RECIP_GAIN_CH1;
    for (int i = 0; i < 2; i++) begin
      err_hist[i]   = '0;
      drive_hist[i] = '0;
    end
  endfunction

  // calibrate, run the control law and update the channel history
  function automatic valve_cmd_t predict_valve_cmd(sensor_item_t it);
    longint     reading;
    longint     offset;
    longint     recip;
    longint     m;
    longint     e;
    longint     acc;
    longint     u;
    valve_cmd_t cmd;
    reading = it.ok ? longint'({it.hi[3:0], it.lo}) : 64'sd0;
    offset  = longint'(cfg_shadow[it.ch ? mlc_pkg::REG_CAL_OFFSET_CH1
                                        : mlc_pkg::REG_CAL_OFFSET_CH0]);
    recip   = longint'($signed(
                cfg_shadow[it.ch ? mlc_pkg::REG_CAL_RECIP_GAIN_CH1
                                 : mlc_pkg::REG_CAL_RECIP_GAIN_CH0]));
    m = ((reading * 16 - offset) * recip) / (64'sd1 << mlc_pkg::MOIST_SHIFT);
    if (m > 1023) m = 1023;
    if (m < -1024) m = -1024;
    e   = longint'(it.sp) - m;
    acc = longint'($signed(cfg_shadow[mlc_pkg::REG_GAIN_ERROR_NOW])) * e
        + longint'($signed(cfg_shadow[mlc_pkg::REG_GAIN_ERROR_PREV]))
          * longint'(err_hist[it.ch])
        + longint'($signed(cfg_shadow[mlc_pkg::REG_GAIN_DRIVE_PREV]))
          * longint'(drive_hist[it.ch]);
    u = acc / (64'sd1 << mlc_pkg::DRIVE_SHIFT);
    if (u > 8388607) u = 8388607;
    if (u < -8388608) u = -8388608;
    err_hist[it.ch]   = e[15:0];
    drive_hist[it.ch] = u[23:0];
    cmd.ch    = it.ch;
    cmd.pwm   = mlc_pkg::PWM_BASE + {1'b0, it.ch};
    if (u >= 1000) cmd.duty = 7'd100;
    else if (u <= 0) cmd.duty = 7'd0;
    else cmd.duty = 7'(u / 10);
    cmd.moist       = m[10:0];
    cmd.addr        = it.addr;
    cmd.rain_valve  = it.rain;
    cmd.mains_valve = ~it.rain;
    return cmd;
  endfunction

  // gap after an input transfer: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one sensor item and record its prediction on transfer
  task automatic send_item(sensor_item_t it);
    int gap;
    in_valid       <= 1'b1;
    channel        <= it.ch;
    adc_byte_hi    <= it.hi;
    adc_byte_lo    <= it.lo;
    transfer_ok    <= it.ok;
    setpoint       <= it.sp;
    rain_present   <= it.rain;
    device_address <= it.addr;
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(predict_valve_cmd(it));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic ch, logic [7:0] hi, logic [7:0] lo, logic ok,
                             logic [6:0] sp, logic rain, logic [6:0] addr);
    sensor_item_t it;
    it = '{ch: ch, hi: hi, lo: lo, ok: ok, sp: sp, rain: rain, addr: addr};
    send_item(it);
  endtask

  function automatic sensor_item_t random_item();
    sensor_item_t it;
    it.ch   = 1'($urandom_range(0, 1));
    it.hi   = 8'($urandom());
    it.lo   = 8'($urandom());
    it.ok   = ($urandom_range(0, 9) != 0);
    it.sp   = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 100))
                                           : 7'($urandom_range(101, 127));
    it.rain = 1'($urandom_range(0, 1));
    it.addr = 7'($urandom());
    return it;
  endfunction

  // hold off input until every result is back and the block has settled
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // one register write, block idle
  task automatic cfg_write(logic [mlc_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= mlc_pkg::REG_CAL_RECIP_GAIN_CH1) cfg_shadow[idx] = data;
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // write all registers in one of the setting styles
  task automatic program_setting(setting_kind_t kind);
    logic [15:0] vals [NUM_REGS];
    vals[mlc_pkg::REG_GAIN_ERROR_NOW]     = mlc_pkg::RST_GAIN_ERROR_NOW;
    vals[mlc_pkg::REG_GAIN_ERROR_PREV]    = mlc_pkg::RST_GAIN_ERROR_PREV;
    vals[mlc_pkg::REG_GAIN_DRIVE_PREV]    = mlc_pkg::RST_GAIN_DRIVE_PREV;
    vals[mlc_pkg::REG_CAL_OFFSET_CH0]     = mlc_pkg::RST_CAL_OFFSET_CH0;
    vals[mlc_pkg::REG_CAL_OFFSET_CH1]     = mlc_pkg::RST_CAL_OFFSET_CH1;
    vals[mlc_pkg::REG_CAL_RECIP_GAIN_CH0] = mlc_pkg::RST_CAL_RECIP_GAIN_CH0;
    vals[mlc_pkg::REG_CAL_RECIP_GAIN_CH1] = mlc_pkg::RST_CAL_RECIP_GAIN_CH1;
    case (kind)
      SET_GENTLE, SET_GENTLE_CAL: begin
        vals[mlc_pkg::REG_GAIN_ERROR_NOW]  = 16'($urandom_range(1, 64));
        vals[mlc_pkg::REG_GAIN_ERROR_PREV] = 16'(int'($urandom_range(0, 64)) - 32);
        vals[mlc_pkg::REG_GAIN_DRIVE_PREV] = 16'($urandom_range(0, 200));
        if (kind == SET_GENTLE_CAL) begin
          vals[mlc_pkg::REG_CAL_OFFSET_CH0]     = 16'($urandom_range(24000, 30000));
          vals[mlc_pkg::REG_CAL_OFFSET_CH1]     = 16'($urandom_range(24000, 32000));
          vals[mlc_pkg::REG_CAL_RECIP_GAIN_CH0] = 16'(-int'($urandom_range(6000, 12000)));
          vals[mlc_pkg::REG_CAL_RECIP_GAIN_CH1] = 16'(-int'($urandom_range(6000, 12000)));
        end
      end
      SET_FULL_RANDOM: begin
        for (int i = 0; i < NUM_REGS; i++) vals[i] = 16'($urandom());
      end
      SET_EXTREMES: begin
        for (int i = 0; i < NUM_REGS; i++) vals[i] = pick_extreme();
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NUM_REGS; i++) cfg_write(mlc_pkg::CFG_INDEX_W'(i), vals[i]);
    if ($urandom_range(0, 1)) cfg_write(REG_INDEX_UNUSED, 16'($urandom()));
    settings_used++;
  endtask

  // result check and receiver back-pressure
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    valve_cmd_t exp_cmd;
    logic       ready_next;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: result transfer with no prediction waiting, expected none, actual 1",
                 $time);
        mismatches++;
      end else begin
        exp_cmd = pending_cmds.pop_front();
        results_seen++;
        check_field("out_channel", exp_cmd.ch, out_channel);
        check_field("pwm_select", exp_cmd.pwm, pwm_select);
        check_field("duty_percent", exp_cmd.duty, duty_percent);
        check_field("moisture", exp_cmd.moist, moisture);
        check_field("out_address", exp_cmd.addr, out_address);
        check_field("rain_valve_open", exp_cmd.rain_valve, rain_valve_open);
        check_field("mains_valve_open", exp_cmd.mains_valve, mains_valve_open);
      end
    end
    // random stalls, short mostly, a few long
    if (steady_flow) begin
      ready_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3:  begin stall_left = $urandom_range(0, 3); ready_next = 1'b0; end
        4:           begin stall_left = $urandom_range(10, 40); ready_next = 1'b0; end
        default:     ready_next = 1'b1;
      endcase
    end
    out_ready <= ready_next;
  end

  // field extremes, failed transfer and setpoint above range at reset values
  task automatic test_default_settings();
    send_fields(1'b0, 8'h00, 8'h00, 1'b1, 7'd0,   1'b0, 7'd0);
    send_fields(1'b1, 8'hFF, 8'hFF, 1'b1, 7'd100, 1'b1, 7'd127);
    send_fields(1'b0, 8'hF0, 8'h00, 1'b1, 7'd127, 1'b0, 7'h7F);
    send_fields(1'b1, 8'h0F, 8'hFF, 1'b0, 7'd50,  1'b0, 7'h00);
    send_fields(1'b0, 8'hAA, 8'h55, 1'b0, 7'd1,   1'b1, 7'h55);
    send_fields(1'b1, 8'h55, 8'hAA, 1'b1, 7'd0,   1'b0, 7'h2A);
    send_fields(1'b0, 8'h08, 8'h00, 1'b1, 7'd60,  1'b1, 7'h01);
    wait_quiet();
  endtask

  // register extremes: moisture and drive saturation both ways
  task automatic test_register_limits();
    cfg_write(REG_INDEX_UNUSED, 16'hFFFF);
    cfg_write(mlc_pkg::REG_GAIN_ERROR_NOW,     16'h7FFF);
    cfg_write(mlc_pkg::REG_GAIN_ERROR_PREV,    16'h7FFF);
    cfg_write(mlc_pkg::REG_GAIN_DRIVE_PREV,    16'h7FFF);
    cfg_write(mlc_pkg::REG_CAL_OFFSET_CH0,     16'h0000);
    cfg_write(mlc_pkg::REG_CAL_OFFSET_CH1,     16'h0000);
    cfg_write(mlc_pkg::REG_CAL_RECIP_GAIN_CH0, 16'h7FFF);
    cfg_write(mlc_pkg::REG_CAL_RECIP_GAIN_CH1, 16'h8000);
    settings_used++;
    for (int i = 0; i < 3; i++) begin
      send_fields(1'b0, 8'h0F, 8'hFF, 1'b1, 7'd0,   1'b0, 7'd3);
      send_fields(1'b1, 8'h0F, 8'hFF, 1'b1, 7'd127, 1'b1, 7'd4);
    end
    wait_quiet();
    cfg_write(mlc_pkg::REG_GAIN_ERROR_NOW,  16'h8000);
    cfg_write(mlc_pkg::REG_GAIN_ERROR_PREV, 16'h8000);
    cfg_write(mlc_pkg::REG_GAIN_DRIVE_PREV, 16'h8000);
    cfg_write(mlc_pkg::REG_CAL_OFFSET_CH1,  16'hFFFF);
    settings_used++;
    send_fields(1'b1, 8'h00, 8'h00, 1'b1, 7'd127, 1'b0, 7'd5);
    send_fields(1'b1, 8'h0F, 8'hFF, 1'b1, 7'd0,   1'b1, 7'd6);
    send_fields(1'b0, 8'h0F, 8'hFF, 1'b0, 7'd100, 1'b0, 7'd7);
    send_fields(1'b1, 8'h0F, 8'hFF, 1'b1, 7'd64,  1'b1, 7'd8);
    wait_quiet();
    program_setting(SET_DEFAULT);
    send_fields(1'b0, 8'h04, 8'h00, 1'b1, 7'd30, 1'b0, 7'd9);
    send_fields(1'b1, 8'h04, 8'h00, 1'b1, 7'd30, 1'b1, 7'd10);
    wait_quiet();
  endtask

  // random items over a series of register settings
  task automatic test_random_settings();
    setting_kind_t plan [NUM_PHASES];
    plan = '{SET_GENTLE, SET_DEFAULT, SET_GENTLE_CAL, SET_FULL_RANDOM,
             SET_GENTLE, SET_EXTREMES, SET_FULL_RANDOM, SET_GENTLE_CAL};
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_setting(plan[p]);
      steady_flow = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item());
        // sender holds off until the block has drained
        if (p == 5 && n == PHASE_ITEMS / 2) wait_quiet();
      end
      wait_quiet();
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    reset_loop_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_settings();
    test_register_limits();
    test_random_settings();
    wait_quiet();
    $display("ran %0d sensor items through %0d register settings with %0d config writes",
             items_sent, settings_used, cfg_writes);
    $display("checked %0d results, %0d field mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("moisture_loop_controller_test OK");
    end else begin
      $display("moisture_loop_controller_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
